>>> src/cscv_pkg.sv
// Shared types, constants and calendar helper functions of the calendar seconds converter.
package cscv_pkg;

    localparam logic [11:0] EPOCH_YEAR        = 12'd2000;
    localparam logic [11:0] YEAR_SPAN         = 12'd178;
    localparam logic [11:0] MIN_YEAR_RST      = 12'd2012;
    localparam logic [11:0] MAX_YEAR_RST      = 12'd2099;
    localparam logic [11:0] LEAPS_BEFORE_BASE = 12'((EPOCH_YEAR - 12'd1) / 4);
    localparam int          WEEK_BASE_OFS     =
        (365 * (int'(EPOCH_YEAR) - 1972) + (int'(EPOCH_YEAR) - 1) / 4 - 1971 / 4) % 7 + 5;
    localparam logic [17:0] WEEKDAY_OFS       = 18'(WEEK_BASE_OFS);

    localparam int          ALU_W      = 33;
    localparam logic [32:0] DAY_SECS   = 33'd86400;
    localparam logic [32:0] HOUR_SECS  = 33'd3600;
    localparam logic [32:0] MIN_SECS   = 33'd60;
    localparam logic [32:0] LEAP_YDAYS = 33'd366;
    localparam logic [32:0] YEAR_DAYS  = 33'd365;

    localparam logic [3:0] DAY_DIV_TOP  = 4'd15;
    localparam logic [3:0] HOUR_DIV_TOP = 4'd4;
    localparam logic [3:0] MIN_DIV_TOP  = 4'd5;
    localparam logic [3:0] LAST_MONTH   = 4'd12;

    typedef struct packed {
        logic        cmd;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  sec;
        logic [31:0] seconds_in;
    } req_item_t;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [15:0] day_count;
        logic [2:0]  weekday;
        logic        valid_res;
        logic        range_error;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } rsp_item_t;

    typedef enum logic [0:0] {
        REG_MIN_YEAR = 1'b0,
        REG_MAX_YEAR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0] min_year;
        logic [11:0] max_year;
    } year_bounds_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
    } alu_ctrl_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } alu_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C0_YEAR,
        S_C0_MON,
        S_C0_DAY,
        S_C0_DEC,
        S_C0_MUL_DAY,
        S_C0_MUL_HOUR,
        S_C0_MUL_MIN,
        S_C0_ADD_SEC,
        S_DAY_DIV,
        S_YEAR_LOOP,
        S_MONTH_LOOP,
        S_HOUR_DIV,
        S_MIN_DIV,
        S_DONE
    } state_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [7:0] month);
        logic [4:0] len;
        case (month)
            8'd1:    len = 5'd31;
            8'd2:    len = leap ? 5'd29 : 5'd28;
            8'd3:    len = 5'd31;
            8'd4:    len = 5'd30;
            8'd5:    len = 5'd31;
            8'd6:    len = 5'd30;
            8'd7:    len = 5'd31;
            8'd8:    len = 5'd31;
            8'd9:    len = 5'd30;
            8'd10:   len = 5'd31;
            8'd11:   len = 5'd30;
            8'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] full);
        logic [8:0] days;
        case (full)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            4'd12:   days = 9'd365;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Since 8 is 1 modulo 7, octal digits are summed and folded twice.
    function automatic logic [2:0] mod7(input logic [17:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
             + 6'(x[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

>>> src/cscv_if.sv
// Handshake channel interfaces for requests, results and register writes.
interface cscv_req_if import cscv_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cscv_rsp_if import cscv_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cscv_cfg_if import cscv_pkg::*; ();
    logic        valid;
    logic        ready;
    cfg_reg_t    addr;
    logic [11:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

>>> src/cscv_alu.sv
// Shared adder and subtractor with borrow flag used by every conversion step.
module cscv_alu import cscv_pkg::*; (
    input  alu_ctrl_t ctrl,
    output alu_res_t  result
);

    logic [ALU_W:0]   sum;
    logic [ALU_W-1:0] b_eff;
    logic             is_sub;

    assign is_sub = (ctrl.op == ALU_SUB);
    assign b_eff  = is_sub ? ~ctrl.b : ctrl.b;
    assign sum    = {1'b0, ctrl.a} + {1'b0, b_eff} + (ALU_W + 1)'(is_sub);

    assign result.res    = sum[ALU_W-1:0];
    assign result.borrow = is_sub & ~sum[ALU_W];

endmodule

>>> src/cscv_cfg.sv
// Year bound registers written through the configuration channel.
module cscv_cfg import cscv_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cscv_cfg_if.sink      cfg,
    output year_bounds_t  bounds
);

    year_bounds_t bounds_reg;
    year_bounds_t bounds_next;

    assign cfg.ready = 1'b1;
    assign bounds    = bounds_reg;

    always_comb
    begin
        bounds_next = bounds_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                REG_MIN_YEAR: bounds_next.min_year = cfg.data;
                REG_MAX_YEAR: bounds_next.max_year = cfg.data;
                default:      bounds_next = bounds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.min_year <= MIN_YEAR_RST;
            bounds_reg.max_year <= MAX_YEAR_RST;
        end
        else
        begin
            bounds_reg <= bounds_next;
        end
    end

endmodule

>>> src/calendar_seconds_converter_core.sv
// Top level of the calendar seconds converter: sequencer and datapath around one shared adder.
// The block takes one request at a time; every step goes through a single 33-bit adder and
// subtractor. A date-time to seconds request steps through the year, month, day, decrement,
// day, hour and minute multiply and second add states, and goes straight to the result when
// the year is out of span. A seconds to date-time request runs a long division by the day
// length, subtracts whole years, then whole months, divides by the hour and minute lengths and
// posts the result; the year and month subtraction loops set how long it runs. The result waits in an
// output register, so the next request can be taken while it is still pending.
module calendar_seconds_converter_core import cscv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cscv_req_if.sink    req,
    cscv_rsp_if.source  rsp,
    cscv_cfg_if.sink    cfg
);

    state_t       state_reg, state_next;
    req_item_t    item_reg, item_next;
    logic [32:0]  acc_reg, acc_next;
    logic [16:0]  rem_reg, rem_next;
    logic [15:0]  q_reg, q_next;
    logic [15:0]  dc_reg, dc_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [11:0]  y_reg, y_next;
    logic [3:0]   m_reg, m_next;
    logic [4:0]   dd_reg, dd_next;
    logic [4:0]   hh_reg, hh_next;
    logic [5:0]   mm_reg, mm_next;
    logic [5:0]   ss_reg, ss_next;
    rsp_item_t    rsp_reg, rsp_next;
    logic         rsp_valid_reg, rsp_valid_next;

    year_bounds_t bounds;
    alu_ctrl_t    alu_ctrl;
    alu_res_t     alu_res;

    logic         req_xfer;
    logic         rsp_free;
    logic         rerr;
    logic         leap;
    logic         valid_c0;
    logic [7:0]   year_off;
    logic [11:0]  leap_cnt;
    logic [16:0]  year_days;
    logic [3:0]   full_months;
    logic         leap_add;
    logic [2:0]   weekday;
    logic         quot_bit;
    logic [32:0]  div_rem;
    logic [15:0]  q_shift;
    rsp_item_t    rsp_load;

    cscv_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .bounds (bounds)
    );

    cscv_alu u_alu (
        .ctrl   (alu_ctrl),
        .result (alu_res)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid & req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;
    assign rsp_free  = ~rsp_valid_reg | rsp.ready;

    assign rerr        = (item_reg.year < EPOCH_YEAR) || (item_reg.year > EPOCH_YEAR + YEAR_SPAN);
    assign leap        = (item_reg.year[1:0] == 2'b00);
    assign year_off    = 8'(item_reg.year - EPOCH_YEAR);
    assign leap_cnt    = ((item_reg.year - 12'd1) >> 2) - LEAPS_BEFORE_BASE;
    assign year_days   = 17'(year_off) * 17'(YEAR_DAYS);
    assign full_months = (item_reg.month == 8'd0) ? 4'd0 :
                         (item_reg.month >= 8'd13) ? LAST_MONTH : 4'(item_reg.month - 8'd1);
    assign leap_add    = leap && (item_reg.month > 8'd2);
    assign weekday     = mod7(18'(dc_reg) + WEEKDAY_OFS) + 3'd1;

    assign valid_c0 = !rerr && (item_reg.hour <= 8'd23) && (item_reg.minute <= 8'd59)
                      && (item_reg.sec <= 8'd59) && (item_reg.year >= bounds.min_year)
                      && (item_reg.year <= bounds.max_year) && (item_reg.month >= 8'd1)
                      && (item_reg.month <= 8'd12) && (item_reg.day >= 8'd1)
                      && (item_reg.day <= 8'(month_len(leap, item_reg.month)));

    assign quot_bit = ~alu_res.borrow;
    assign div_rem  = quot_bit ? alu_res.res : acc_reg;
    assign q_shift  = {q_reg[14:0], quot_bit};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_xfer)
                    state_next = req.data.cmd ? S_DAY_DIV : S_C0_YEAR;
            S_C0_YEAR:     state_next = rerr ? S_DONE : S_C0_MON;
            S_C0_MON:      state_next = S_C0_DAY;
            S_C0_DAY:      state_next = S_C0_DEC;
            S_C0_DEC:      state_next = S_C0_MUL_DAY;
            S_C0_MUL_DAY:  state_next = S_C0_MUL_HOUR;
            S_C0_MUL_HOUR: state_next = S_C0_MUL_MIN;
            S_C0_MUL_MIN:  state_next = S_C0_ADD_SEC;
            S_C0_ADD_SEC:  state_next = S_DONE;
            S_DAY_DIV:
                if (cnt_reg == 4'd0)
                    state_next = S_YEAR_LOOP;
            S_YEAR_LOOP:
                if (alu_res.borrow)
                    state_next = S_MONTH_LOOP;
            S_MONTH_LOOP:
                if (alu_res.borrow || (m_reg == LAST_MONTH))
                    state_next = S_HOUR_DIV;
            S_HOUR_DIV:
                if (cnt_reg == 4'd0)
                    state_next = S_MIN_DIV;
            S_MIN_DIV:
                if (cnt_reg == 4'd0)
                    state_next = S_DONE;
            S_DONE:
                if (rsp_free)
                    state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        alu_ctrl.op = ALU_ADD;
        alu_ctrl.a  = '0;
        alu_ctrl.b  = '0;
        case (state_reg)
            S_C0_YEAR:
            begin
                alu_ctrl.a = 33'(year_days);
                alu_ctrl.b = 33'(leap_cnt);
            end
            S_C0_MON:
            begin
                alu_ctrl.a = acc_reg;
                alu_ctrl.b = 33'(cum_days(full_months)) + 33'(leap_add);
            end
            S_C0_DAY:
            begin
                alu_ctrl.a = acc_reg;
                alu_ctrl.b = 33'(item_reg.day);
            end
            S_C0_DEC:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = 33'd1;
            end
            S_C0_MUL_DAY:
            begin
                alu_ctrl.b = 33'(dc_reg) * DAY_SECS;
            end
            S_C0_MUL_HOUR:
            begin
                alu_ctrl.a = acc_reg;
                alu_ctrl.b = 33'(item_reg.hour) * HOUR_SECS;
            end
            S_C0_MUL_MIN:
            begin
                alu_ctrl.a = acc_reg;
                alu_ctrl.b = 33'(item_reg.minute) * MIN_SECS;
            end
            S_C0_ADD_SEC:
            begin
                alu_ctrl.a = acc_reg;
                alu_ctrl.b = 33'(item_reg.sec);
            end
            S_DAY_DIV:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = DAY_SECS << cnt_reg;
            end
            S_YEAR_LOOP:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = (y_reg[1:0] == 2'b00) ? LEAP_YDAYS : YEAR_DAYS;
            end
            S_MONTH_LOOP:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = 33'(month_len(y_reg[1:0] == 2'b00, 8'(m_reg)));
            end
            S_HOUR_DIV:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = HOUR_SECS << cnt_reg;
            end
            S_MIN_DIV:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = acc_reg;
                alu_ctrl.b  = MIN_SECS << cnt_reg;
            end
            default:
            begin
                alu_ctrl.op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        rsp_load             = '0;
        rsp_load.day_count   = dc_reg;
        rsp_load.weekday     = weekday;
        if (item_reg.cmd)
        begin
            rsp_load.seconds_out = item_reg.seconds_in;
            rsp_load.year_out    = y_reg;
            rsp_load.month_out   = m_reg;
            rsp_load.day_out     = dd_reg;
            rsp_load.hour_out    = hh_reg;
            rsp_load.minute_out  = mm_reg;
            rsp_load.second_out  = ss_reg;
        end
        else
        begin
            rsp_load.seconds_out = acc_reg[31:0];
            rsp_load.valid_res   = valid_c0;
            rsp_load.range_error = rerr;
        end
    end

    always_comb
    begin
        item_next      = item_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        dc_next        = dc_reg;
        cnt_next       = cnt_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        dd_next        = dd_reg;
        hh_next        = hh_reg;
        mm_next        = mm_reg;
        ss_next        = ss_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    item_next = req.data;
                    acc_next  = req.data.cmd ? {1'b0, req.data.seconds_in} : '0;
                    dc_next   = '0;
                    q_next    = '0;
                    cnt_next  = DAY_DIV_TOP;
                end
            end
            S_C0_YEAR:
            begin
                if (!rerr)
                    acc_next = alu_res.res;
            end
            S_C0_MON, S_C0_DAY, S_C0_MUL_DAY, S_C0_MUL_HOUR, S_C0_MUL_MIN, S_C0_ADD_SEC:
            begin
                acc_next = alu_res.res;
            end
            S_C0_DEC:
            begin
                acc_next = alu_res.res;
                dc_next  = alu_res.res[15:0];
            end
            S_DAY_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    dc_next  = q_shift;
                    rem_next = div_rem[16:0];
                    acc_next = 33'(q_shift);
                    y_next   = EPOCH_YEAR;
                end
                else
                begin
                    acc_next = div_rem;
                    q_next   = q_shift;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_YEAR_LOOP:
            begin
                if (alu_res.borrow)
                begin
                    m_next = 4'd1;
                end
                else
                begin
                    acc_next = alu_res.res;
                    y_next   = y_reg + 12'd1;
                end
            end
            S_MONTH_LOOP:
            begin
                if (alu_res.borrow || (m_reg == LAST_MONTH))
                begin
                    dd_next  = acc_reg[4:0] + 5'd1;
                    acc_next = 33'(rem_reg);
                    cnt_next = HOUR_DIV_TOP;
                    q_next   = '0;
                end
                else
                begin
                    acc_next = alu_res.res;
                    m_next   = m_reg + 4'd1;
                end
            end
            S_HOUR_DIV:
            begin
                acc_next = div_rem;
                if (cnt_reg == 4'd0)
                begin
                    hh_next  = q_shift[4:0];
                    cnt_next = MIN_DIV_TOP;
                    q_next   = '0;
                end
                else
                begin
                    q_next   = q_shift;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_MIN_DIV:
            begin
                acc_next = div_rem;
                if (cnt_reg == 4'd0)
                begin
                    mm_next = q_shift[5:0];
                    ss_next = div_rem[5:0];
                end
                else
                begin
                    q_next   = q_shift;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = rsp_load;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dc_reg   <= dc_next;
        cnt_reg  <= cnt_next;
        y_reg    <= y_next;
        m_reg    <= m_next;
        dd_reg   <= dd_next;
        hh_reg   <= hh_next;
        mm_reg   <= mm_next;
        ss_reg   <= ss_next;
        rsp_reg  <= rsp_next;
    end

endmodule

>>> src/cscv_checker.sv
// Port-level assertions for the calendar seconds converter and their bind to the top level.
module cscv_checker import cscv_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("Stalled result changed or was dropped.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request taken while another one is in progress.");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.range_error |->
            rsp_data.seconds_out == 32'd0 && rsp_data.day_count == 16'd0
            && !rsp_data.valid_res)
        else $error("Out-of-span year gave a nonzero count or a valid flag.");

    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.weekday != 3'd0)
        else $error("Weekday of zero in a result.");

endmodule

bind calendar_seconds_converter_core cscv_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
